/* sv/tsb_pkg.sv */
// shared types, constants and sequence helpers for the sack scoreboard
package tsb_pkg;

    localparam int ENTRIES = 16;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);

    localparam logic [7:0] TCP_FACK_REXMTTHRESH = 8'd3;

    // configuration register indexes
    localparam logic CFG_FACK_ENABLE  = 1'b0;
    localparam logic CFG_REXMT_THRESH = 1'b1;

    // item kinds
    localparam logic [1:0] MODE_ACK   = 2'd0;
    localparam logic [1:0] MODE_HOLE  = 2'd1;
    localparam logic [1:0] MODE_MARK  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic [31:0] st;
        logic [31:0] en;
        logic [31:0] rp;
        logic [31:0] sm;
        logic [7:0]  oc;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_INSERT,
        CMD_DELETE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op         op;
        logic [IW-1:0]   idx;
        t_entry          data;
    } t_cmd;

    // sequence order modulo 2^32
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic f_leq(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || f_lt(a, b);
    endfunction

    function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
        return f_lt(b, a);
    endfunction

    function automatic logic f_geq(input logic [31:0] a, input logic [31:0] b);
        return f_leq(b, a);
    endfunction

    // signed difference applied to the byte count, saturating at both ends
    function automatic logic [31:0] f_rexmt_update(input logic [31:0] total,
                                                  input logic [31:0] diff,
                                                  input logic        subtract);
        logic signed [33:0] d;
        logic signed [33:0] t;
        d = signed'({{2{diff[31]}}, diff});
        t = signed'({2'b00, total}) + (subtract ? -d : d);
        if (t < 0) begin
            return 32'd0;
        end else if (t > signed'({2'b00, 32'hFFFF_FFFF})) begin
            return 32'hFFFF_FFFF;
        end
        return t[31:0];
    endfunction

endpackage

/* sv/tcp_sack_scoreboard_top.sv */
// sack scoreboard top: item sequencer over the entry cell row
// clear items go straight to the done state; hole and mark items walk the entries,
// and an ack/sack item walks them in its ack, merge and forward-ack passes; one item at a time
// the walks are set by the single read port of the cell row, one entry a cycle
// the result waits in an output register while the next item is accepted
// reset clears control state and the entry count; entry contents stay undefined
module tcp_sack_scoreboard_top
    import tsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_ack_number,
    input  logic        i_block_valid,
    input  logic        i_first_block,
    input  logic        i_last_block,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_end,
    input  logic [31:0] i_send_max,
    input  logic [31:0] i_send_unacked,
    input  logic        i_reset_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [31:0] o_hole_start,
    output logic [31:0] o_hole_end,
    output logic [31:0] o_hole_length,
    output logic [31:0] o_retransmitted_bytes,
    output logic [31:0] o_forward_ack
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_ACK    = 15'b000000000000010,
        S_BLK    = 15'b000000000000100,
        S_SCAN   = 15'b000000000001000,
        S_INS    = 15'b000000000010000,
        S_INS2   = 15'b000000000100000,
        S_MERGE  = 15'b000000001000000,
        S_MERGE2 = 15'b000000010000000,
        S_DEL    = 15'b000000100000000,
        S_WB     = 15'b000001000000000,
        S_FACK0  = 15'b000010000000000,
        S_FACK   = 15'b000100000000000,
        S_HOLE   = 15'b001000000000000,
        S_MARK   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    // control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_la, n_la;
    logic [31:0]   r_total, n_total;
    logic [31:0]   r_hs, n_hs;
    logic [31:0]   r_pfe, n_pfe;
    logic          r_fack_en;
    logic [7:0]    r_thr;
    logic          r_ov, n_ov;

    // working payload registers
    logic [31:0]   r_pen, n_pen;
    logic [31:0]   r_enq, n_enq;
    logic [31:0]   r_ref, n_ref;
    logic [31:0]   r_s, n_s;
    logic [31:0]   r_e, n_e;
    t_entry        r_new, n_new;
    logic          r_status, n_status;
    logic [31:0]   r_hstart, n_hstart;
    logic [31:0]   r_hend, n_hend;
    logic [31:0]   r_hlen, n_hlen;
    logic [31:0]   r_ack, n_ack;
    logic          r_bv, n_bv;
    logic          r_last, n_last;
    logic [31:0]   r_smax, n_smax;
    logic [31:0]   r_suna, n_suna;
    logic          r_rc, n_rc;

    // output register
    logic          r_o_status;
    logic [31:0]   r_o_hstart, r_o_hend, r_o_hlen, r_o_total, r_o_fack;

    t_entry w_rd;
    t_cmd   w_cmd;
    logic   w_in_acc;
    logic   w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_ov && !i_stall;
    assign o_stall   = (r_state != S_IDLE);

    tsb_chain u_chain (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_rd_idx (r_k[IW-1:0]),
        .o_rd     (w_rd)
    );

    // sequencer
    always_comb begin
        t_entry      v_ent;
        logic [31:0] v_s, v_e, v_rp;
        logic        v_acc_en, v_acc_sub, v_pass;
        logic [31:0] v_acc_diff;

        n_state = r_state;   n_k = r_k;       n_cnt = r_cnt;   n_la = r_la;
        n_total = r_total;   n_hs = r_hs;     n_pfe = r_pfe;   n_ov = r_ov;
        n_pen = r_pen;       n_enq = r_enq;   n_ref = r_ref;   n_s = r_s;
        n_e = r_e;           n_new = r_new;   n_status = r_status;
        n_hstart = r_hstart; n_hend = r_hend; n_hlen = r_hlen;
        n_ack = r_ack;       n_bv = r_bv;     n_last = r_last; n_smax = r_smax;
        n_suna = r_suna;     n_rc = r_rc;
        v_ent = w_rd;  v_s = r_s;  v_e = r_e;  v_rp = w_rd.rp;  v_pass = 1'b0;
        v_acc_en = 1'b0;  v_acc_sub = 1'b1;  v_acc_diff = '0;
        w_cmd.op   = CMD_NONE;
        w_cmd.idx  = r_k[IW-1:0];
        w_cmd.data = w_rd;

        if (w_out_acc) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_ack = i_ack_number;  n_bv = i_block_valid;  n_last = i_last_block;
                    n_s = i_range_start;   n_e = i_range_end;
                    n_smax = i_send_max;   n_suna = i_send_unacked;
                    n_rc = i_reset_count;
                    n_status = 1'b0;  n_hstart = '0;  n_hend = '0;  n_hlen = '0;
                    n_k = '0;
                    unique case (i_mode)
                        MODE_ACK: begin
                            if (i_first_block) begin
                                n_pfe = i_ack_number;
                                n_state = f_gt(i_ack_number, r_la) ? S_ACK : S_BLK;
                            end else begin
                                n_state = S_BLK;
                            end
                        end
                        MODE_HOLE: n_state = S_HOLE;
                        MODE_MARK: begin
                            v_acc_en = 1'b1;  v_acc_sub = 1'b0;
                            v_acc_diff = i_range_end - i_range_start;
                            n_state = S_MARK;
                        end
                        default: begin
                            n_cnt = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // cumulative ack walk over the head entry
            S_ACK: begin
                if (r_cnt == '0) begin
                    n_la = r_ack;
                    n_state = S_BLK;
                end else begin
                    v_acc_en = 1'b1;
                    if (f_gt(r_ack, w_rd.rp)) begin
                        v_acc_diff = w_rd.rp - r_la;
                        v_rp = r_ack;
                    end else begin
                        v_acc_diff = r_ack - r_la;
                    end
                    if (f_geq(r_ack, w_rd.en)) begin
                        n_la = w_rd.en;
                        w_cmd.op = CMD_DELETE;
                        n_cnt = r_cnt - CW'(1);
                    end else begin
                        v_ent.rp = v_rp;
                        w_cmd.op = CMD_WRITE;
                        w_cmd.data = v_ent;
                        if (f_geq(r_ack, w_rd.st)) n_cnt = '0;
                        n_la = r_ack;
                        n_state = S_BLK;
                    end
                end
            end

            // clip the block and decide where it goes
            S_BLK: begin
                if (!r_bv) begin
                    n_state = S_FACK0;
                end else begin
                    if (f_gt(r_e, r_pfe)) n_pfe = r_e;
                    v_e = f_gt(r_e, r_smax) ? r_smax : r_e;
                    v_s = f_lt(r_s, r_suna) ? r_suna : r_s;
                    n_s = v_s;  n_e = v_e;
                    n_state = S_FACK0;
                    if (f_gt(v_s, v_e)) begin
                        n_state = S_FACK0;
                    end else if (r_cnt == '0) begin
                        n_la = r_ack;
                        w_cmd.op = CMD_INSERT;
                        w_cmd.data = '{st: v_s, en: v_e, rp: r_ack, sm: r_smax, oc: 8'd0};
                        n_cnt = CW'(1);
                    end else if (f_leq(v_e, r_la)) begin
                        n_state = S_FACK0;
                    end else if (f_leq(v_s, r_la) || f_leq(v_s, r_suna)) begin
                        n_cnt = '0;
                    end else if (f_leq(v_s, w_rd.st)) begin
                        n_state = S_INS;
                    end else if (f_leq(v_e, w_rd.en)) begin
                        n_state = S_FACK0;
                    end else begin
                        n_pen = w_rd.en;
                        n_k = CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end

            // find the first entry that starts at or after the block
            S_SCAN: begin
                if (r_k >= r_cnt) begin
                    if (r_cnt >= CW'(ENTRIES)) begin
                        n_cnt = '0;  n_status = 1'b1;  n_state = S_DONE;
                    end else begin
                        w_cmd.op = CMD_INSERT;
                        w_cmd.data = '{st: r_s, en: r_e, rp: r_pen, sm: r_smax, oc: 8'd0};
                        n_cnt = r_cnt + CW'(1);
                        n_state = S_MERGE;
                    end
                end else if (!f_leq(r_s, w_rd.st)) begin
                    n_pen = w_rd.en;
                    n_k = r_k + CW'(1);
                end else if (f_leq(r_s, r_pen)) begin
                    if (f_leq(r_e, r_pen)) begin
                        n_state = S_FACK0;
                    end else begin
                        v_acc_en = 1'b1;
                        if (f_gt(r_e, w_rd.rp)) begin
                            v_acc_diff = w_rd.rp - r_pen;
                            v_ent.rp = r_e;
                            w_cmd.op = CMD_WRITE;
                            w_cmd.data = v_ent;
                        end else begin
                            v_acc_diff = r_e - r_pen;
                        end
                        n_pen = r_e;
                        n_state = S_MERGE;
                    end
                end else begin
                    n_state = S_INS;
                end
            end

            // split the retransmit pointer and stage the new entry
            S_INS: begin
                if (f_lt(r_s, w_rd.rp)) begin
                    v_acc_en = 1'b1;
                    v_acc_diff = f_lt(r_e, w_rd.rp) ? (r_e - r_s) : (w_rd.rp - r_s);
                end
                if (r_cnt >= CW'(ENTRIES)) begin
                    n_cnt = '0;  n_status = 1'b1;  n_state = S_DONE;
                end else begin
                    if (f_leq(r_s, w_rd.rp)) begin
                        v_rp = r_s;
                        if (f_gt(r_e, w_rd.rp)) v_ent.rp = r_e;
                    end else begin
                        v_rp = w_rd.rp;
                        v_ent.rp = r_e;
                    end
                    w_cmd.op = CMD_WRITE;
                    w_cmd.data = v_ent;
                    n_new = '{st: r_s, en: r_e, rp: v_rp, sm: w_rd.sm, oc: w_rd.oc};
                    n_state = S_INS2;
                end
            end

            S_INS2: begin
                w_cmd.op = CMD_INSERT;
                w_cmd.data = r_new;
                n_cnt = r_cnt + CW'(1);
                n_pen = r_e;
                n_k = r_k + CW'(1);
                n_state = S_MERGE;
            end

            // absorb following entries that the grown interval reaches
            S_MERGE: begin
                if (r_k >= r_cnt || !f_geq(r_pen, w_rd.st)) begin
                    n_k = r_k - CW'(1);
                    n_state = S_WB;
                end else if (f_gt(r_pen, w_rd.en)) begin
                    if ((r_k + CW'(1)) < r_cnt) begin
                        n_enq = w_rd.en;
                        n_k = r_k + CW'(1);
                        n_state = S_MERGE2;
                    end else begin
                        w_cmd.op = CMD_DELETE;
                        n_cnt = r_cnt - CW'(1);
                    end
                end else begin
                    n_pen = w_rd.en;
                    w_cmd.op = CMD_DELETE;
                    n_cnt = r_cnt - CW'(1);
                end
            end

            S_MERGE2: begin
                v_acc_en = 1'b1;
                if (f_gt(r_pen, w_rd.rp)) begin
                    v_acc_diff = w_rd.rp - r_enq;
                    v_ent.rp = r_pen;
                    w_cmd.op = CMD_WRITE;
                    w_cmd.data = v_ent;
                end else begin
                    v_acc_diff = r_pen - r_enq;
                end
                n_k = r_k - CW'(1);
                n_state = S_DEL;
            end

            S_DEL: begin
                w_cmd.op = CMD_DELETE;
                n_cnt = r_cnt - CW'(1);
                n_state = S_MERGE;
            end

            // write the merged end back into its entry
            S_WB: begin
                v_ent.en = r_pen;
                w_cmd.op = CMD_WRITE;
                w_cmd.data = v_ent;
                n_state = S_FACK0;
            end

            S_FACK0: begin
                n_state = S_DONE;
                if (r_last && r_fack_en) begin
                    if (f_gt(r_pfe, r_hs)) n_hs = r_pfe;
                    if (r_cnt != '0) begin
                        n_k = '0;
                        n_ref = r_la;
                        n_state = S_FACK;
                    end
                end
            end

            // forward-ack pass, one entry a cycle
            S_FACK: begin
                if (f_lt(w_rd.sm, r_hs) && w_rd.rp != r_ref) begin
                    v_acc_en = 1'b1;
                    v_acc_diff = w_rd.rp - r_ref;
                    v_ent.rp = r_ref;
                    v_ent.oc = 8'd0;
                    v_ent.sm = r_smax;
                end
                if (f_leq(v_ent.rp, r_pfe)) begin
                    v_pass = 1'b1;
                    if (v_ent.oc != 8'hFF) v_ent.oc = v_ent.oc + 8'd1;
                end
                w_cmd.op = CMD_WRITE;
                w_cmd.data = v_ent;
                n_ref = w_rd.en;
                n_k = r_k + CW'(1);
                if ((r_k + CW'(1)) < r_cnt && (r_k == '0 || v_pass)) n_state = S_FACK;
                else n_state = S_DONE;
            end

            // next hole search
            S_HOLE: begin
                if (r_k >= r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    v_s = f_lt(w_rd.rp, r_suna) ? r_suna : w_rd.rp;
                    v_e = f_gt(w_rd.st, r_smax) ? r_smax : w_rd.st;
                    if (f_lt(w_rd.rp, w_rd.st) && !(r_fack_en && w_rd.oc < r_thr)
                        && !f_geq(v_s, v_e)) begin
                        n_hstart = v_s;  n_hend = v_e;  n_hlen = v_e - v_s;
                        n_state = S_DONE;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
            end

            // retransmitted range marking
            S_MARK: begin
                if (r_k >= r_cnt) begin
                    n_state = S_DONE;
                end else if (!f_lt(r_s, w_rd.st)) begin
                    n_k = r_k + CW'(1);
                end else if (f_leq(r_e, w_rd.st)) begin
                    if (f_geq(r_e, w_rd.rp)) begin
                        v_ent.rp = r_e;
                        v_ent.sm = r_smax;
                        w_cmd.op = CMD_WRITE;
                        w_cmd.data = v_ent;
                    end
                    n_state = S_DONE;
                end else begin
                    v_ent.rp = w_rd.st;
                    v_ent.sm = r_smax;
                    w_cmd.op = CMD_WRITE;
                    w_cmd.data = v_ent;
                    n_k = r_k + CW'(1);
                end
            end

            S_DONE: begin
                if (r_rc && !r_bv && !r_last && 1'b0) n_state = S_DONE;
                if (!r_ov || w_out_acc) begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // shared byte-count adder
        if (v_acc_en) n_total = f_rexmt_update(r_total, v_acc_diff, v_acc_sub);
        if (r_state == S_IDLE && w_in_acc && i_mode == MODE_CLEAR && i_reset_count)
            n_total = '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_cnt     <= '0;
            r_la      <= '0;
            r_total   <= '0;
            r_hs      <= '0;
            r_pfe     <= '0;
            r_fack_en <= 1'b1;
            r_thr     <= TCP_FACK_REXMTTHRESH;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_la    <= n_la;
            r_total <= n_total;
            r_hs    <= n_hs;
            r_pfe   <= n_pfe;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FACK_ENABLE) r_fack_en <= i_cfg_data[0];
                if (i_cfg_index == CFG_REXMT_THRESH) r_thr <= i_cfg_data;
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_pen <= n_pen;   r_enq <= n_enq;   r_ref <= n_ref;
        r_s <= n_s;       r_e <= n_e;       r_new <= n_new;
        r_status <= n_status;
        r_hstart <= n_hstart;  r_hend <= n_hend;  r_hlen <= n_hlen;
        r_ack <= n_ack;   r_bv <= n_bv;     r_last <= n_last;
        r_smax <= n_smax; r_suna <= n_suna; r_rc <= n_rc;
        if (r_state == S_DONE && (!r_ov || w_out_acc)) begin
            r_o_status <= r_status;
            r_o_hstart <= r_hstart;
            r_o_hend   <= r_hend;
            r_o_hlen   <= r_hlen;
            r_o_total  <= r_total;
            r_o_fack   <= r_hs;
        end
    end

    assign o_valid               = r_ov;
    assign o_status              = r_o_status;
    assign o_hole_start          = r_o_hstart;
    assign o_hole_end            = r_o_hend;
    assign o_hole_length         = r_o_hlen;
    assign o_retransmitted_bytes = r_o_total;
    assign o_forward_ack         = r_o_fack;

`ifndef NO_ASSERTIONS
    // the table never holds more entries than cells
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    // a full-table clear never reports a hole
    a_status_no_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_hole_length == '0)
        else $error("hole reported with full-table status");

    // hole length agrees with its bounds
    a_hole_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hole_length == o_hole_end - o_hole_start)
        else $error("hole length mismatch");

    // an accepted item raises the stall in the following cycle, holding off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted back to back");
`endif

endmodule

/* sv/tsb_cell.sv */
// one scoreboard entry that loads from the bus or either neighbor
module tsb_cell
    import tsb_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_entry   i_left,
    input  t_entry   i_right,
    input  t_entry   i_bus,
    output t_entry   o_entry
);

    t_entry r_entry;

    // entry storage
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD:       r_entry <= i_bus;
            CELL_FROM_LEFT:  r_entry <= i_left;
            CELL_FROM_RIGHT: r_entry <= i_right;
            default:         r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

/* sv/tsb_chain.sv */
// row of entry cells with shift insert, shift delete and one read port
module tsb_chain
    import tsb_pkg::*;
(
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_rd_idx,
    output t_entry        o_rd
);

    t_entry w_entry [ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_cell_op w_op;
            t_entry   w_left;
            t_entry   w_right;

            // neighbor links, the row ends are tied to the bus
            if (gi == 0) begin : g_first
                assign w_left = i_cmd.data;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == ENTRIES - 1) begin : g_last
                assign w_right = i_cmd.data;
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end

            // per-cell operation from the row command
            always_comb begin
                w_op = CELL_HOLD;
                unique case (i_cmd.op)
                    CMD_WRITE: begin
                        if (i_cmd.idx == IW'(gi)) w_op = CELL_LOAD;
                    end
                    CMD_INSERT: begin
                        if (i_cmd.idx == IW'(gi)) w_op = CELL_LOAD;
                        else if (i_cmd.idx < IW'(gi)) w_op = CELL_FROM_LEFT;
                    end
                    CMD_DELETE: begin
                        if (i_cmd.idx <= IW'(gi) && gi != ENTRIES - 1) w_op = CELL_FROM_RIGHT;
                    end
                    default: w_op = CELL_HOLD;
                endcase
            end

            tsb_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_left  (w_left),
                .i_right (w_right),
                .i_bus   (i_cmd.data),
                .o_entry (w_entry[gi])
            );
        end
    endgenerate

    assign o_rd = w_entry[i_rd_idx];

endmodule
